// ===== design/pdtx_pkg.sv =====
// Shared types, constants and microcode for the PD transmit token framer.
`default_nettype none
package pdtx_pkg;

	localparam int MAX_OBJECTS_DEF = 7;
	localparam int NUM_OBJ_FIELDS  = 7;
	localparam int OBJ_W           = 32;
	localparam int HDR_W           = 16;
	localparam int CNT_W           = 3;
	localparam int TYPE_W          = 2;
	localparam int REM_W           = CNT_W + 2;
	localparam int HDR_LSB         = 0;
	localparam int CNT_LSB         = HDR_LSB + HDR_W;
	localparam int OBJ_LSB         = CNT_LSB + CNT_W;
	localparam int S_TDATA_BITS    = OBJ_LSB + NUM_OBJ_FIELDS * OBJ_W;
	localparam int S_TDATA_W       = ((S_TDATA_BITS + 7) / 8) * 8;
	localparam int CNT_SHIFT       = 12;

	localparam logic [TYPE_W-1:0] TYPE_SOP     = 2'd0;
	localparam logic [TYPE_W-1:0] TYPE_SOP_P   = 2'd1;
	localparam logic [TYPE_W-1:0] TYPE_SOP_PP  = 2'd2;
	localparam logic [TYPE_W-1:0] TYPE_INVALID = 2'd3;

	localparam logic [7:0] TOK_SYNC1   = 8'h12;
	localparam logic [7:0] TOK_SYNC2   = 8'h13;
	localparam logic [7:0] TOK_SYNC3   = 8'h1B;
	localparam logic [7:0] TOK_JAMCRC  = 8'hFF;
	localparam logic [7:0] TOK_EOP     = 8'h14;
	localparam logic [7:0] TOK_TXOFF   = 8'hFE;
	localparam logic [7:0] TOK_TXON    = 8'hA1;
	localparam logic [7:0] TOK_PACKSYM = 8'h80;

	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_SOP0  = 4'd0;
	localparam logic [PC_W-1:0] PC_SOP1  = 4'd1;
	localparam logic [PC_W-1:0] PC_SOP2  = 4'd2;
	localparam logic [PC_W-1:0] PC_SOP3  = 4'd3;
	localparam logic [PC_W-1:0] PC_PACK  = 4'd4;
	localparam logic [PC_W-1:0] PC_HLO   = 4'd5;
	localparam logic [PC_W-1:0] PC_HHI   = 4'd6;
	localparam logic [PC_W-1:0] PC_OBJ   = 4'd7;
	localparam logic [PC_W-1:0] PC_JAM   = 4'd8;
	localparam logic [PC_W-1:0] PC_EOP   = 4'd9;
	localparam logic [PC_W-1:0] PC_TXOFF = 4'd10;
	localparam logic [PC_W-1:0] PC_TXON  = 4'd11;
	localparam logic [PC_W-1:0] PC_ERR   = 4'd12;

	localparam logic [2:0] SRC_ZERO = 3'd0;
	localparam logic [2:0] SRC_SOP  = 3'd1;
	localparam logic [2:0] SRC_PACK = 3'd2;
	localparam logic [2:0] SRC_HLO  = 3'd3;
	localparam logic [2:0] SRC_HHI  = 3'd4;
	localparam logic [2:0] SRC_OBJ  = 3'd5;
	localparam logic [2:0] SRC_TOK  = 3'd6;

	localparam logic [1:0] JC_NEXT  = 2'd0;
	localparam logic [1:0] JC_NOOBJ = 2'd1;
	localparam logic [1:0] JC_MORE  = 2'd2;
	localparam logic [1:0] JC_END   = 2'd3;

	typedef struct packed {
		logic [2:0]      src;
		logic [7:0]      tok;
		logic [1:0]      idx;
		logic            last;
		logic            bad;
		logic [1:0]      jc;
		logic [PC_W-1:0] tgt;
	} ctl_word_t;

	typedef struct packed {
		logic start;
		logic bad;
	} seq_cmd_t;

	typedef struct packed {
		logic no_obj;
		logic more;
	} seq_cond_t;

	function automatic logic [7:0] sop_token(input logic [TYPE_W-1:0] kind,
		input logic [1:0] idx);
		logic [7:0] t;
		t = TOK_SYNC1;
		unique case (kind)
			TYPE_SOP:    t = (idx == 2'd3) ? TOK_SYNC2 : TOK_SYNC1;
			TYPE_SOP_P:  t = idx[1] ? TOK_SYNC3 : TOK_SYNC1;
			TYPE_SOP_PP: t = idx[0] ? TOK_SYNC3 : TOK_SYNC1;
			default:     t = TOK_SYNC1;
		endcase
		return t;
	endfunction

	function automatic ctl_word_t ucode(input logic [PC_W-1:0] pc);
		ctl_word_t w;
		w = '{src: SRC_ZERO, tok: 8'h00, idx: 2'd0, last: 1'b0, bad: 1'b0,
			jc: JC_NEXT, tgt: PC_SOP0};
		unique case (pc)
			PC_SOP0:  begin w.src = SRC_SOP; w.idx = 2'd0; end
			PC_SOP1:  begin w.src = SRC_SOP; w.idx = 2'd1; end
			PC_SOP2:  begin w.src = SRC_SOP; w.idx = 2'd2; end
			PC_SOP3:  begin w.src = SRC_SOP; w.idx = 2'd3; end
			PC_PACK:  w.src = SRC_PACK;
			PC_HLO:   w.src = SRC_HLO;
			PC_HHI:   begin w.src = SRC_HHI; w.jc = JC_NOOBJ; w.tgt = PC_JAM; end
			PC_OBJ:   begin w.src = SRC_OBJ; w.jc = JC_MORE; w.tgt = PC_OBJ; end
			PC_JAM:   begin w.src = SRC_TOK; w.tok = TOK_JAMCRC; end
			PC_EOP:   begin w.src = SRC_TOK; w.tok = TOK_EOP; end
			PC_TXOFF: begin w.src = SRC_TOK; w.tok = TOK_TXOFF; end
			PC_TXON:  begin
				w.src = SRC_TOK; w.tok = TOK_TXON; w.last = 1'b1; w.jc = JC_END;
			end
			PC_ERR:   begin w.last = 1'b1; w.bad = 1'b1; w.jc = JC_END; end
			default:  begin w.last = 1'b1; w.jc = JC_END; end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== design/pdtx_useq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none
module pdtx_useq
	import pdtx_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire seq_cmd_t  cmd,
	input  wire logic      step,
	input  wire seq_cond_t cond,
	output ctl_word_t      ctl,
	output logic           busy
);

	logic [PC_W-1:0] pc_q;
	logic            busy_q;
	logic            take;

	assign ctl  = ucode(pc_q);
	assign busy = busy_q;
	assign take = (ctl.jc == JC_NOOBJ && cond.no_obj) || (ctl.jc == JC_MORE && cond.more);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= PC_SOP0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			pc_q   <= cmd.bad ? PC_ERR : PC_SOP0;
		end else if (step) begin
			priority if (ctl.jc == JC_END) begin
				busy_q <= 1'b0;
			end else if (take) begin
				pc_q <= ctl.tgt;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/pd_tx_token_framer.sv =====
// Top level of the PD transmit token framer: message registers, byte datapath, output beat.
//
//  channel  dir  tdata                                   tuser      tlast
//  s_axis   in   header, obj_cnt, object_0..6 (248)      os_type    -
//  m_axis   out  fifo_byte (8)                           bad_request last_byte
//
// One message gives 11+4N output beats, one per cycle while m_axis_tready is high;
// an invalid type or oversized count gives one beat. The microcode sequencer sets
// the pace: one control word per beat. The sequencer goes idle, raising s_axis_tready,
// as the last beat enters the output register, so a new message is accepted only after
// the previous one has been stepped out. Reset clears the sequencer and the output valid.
// A stalled output beat holds the sequencer.
`default_nettype none
module pd_tx_token_framer
	import pdtx_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// header[15:0], obj_cnt[18:16], object_0 .. object_6 from bit 19, zero pad
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
	// os_type[1:0]
	input  wire logic [TYPE_W-1:0]    s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// fifo_byte[7:0]
	output logic [7:0]                m_axis_tdata,
	// bad_request[0]
	output logic                      m_axis_tuser,
	output logic                      m_axis_tlast
);

	localparam int OBJ_SR_W = MAX_OBJECTS * OBJ_W;

	logic [HDR_W-1:0]    hdr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TYPE_W-1:0]   type_q;
	logic [REM_W-1:0]    rem_q;
	logic [OBJ_SR_W-1:0] obj_sr_q;
	logic [OBJ_SR_W-1:0] obj_load;

	logic       m_valid_q;
	logic [7:0] m_data_q;
	logic       m_last_q;
	logic       m_bad_q;

	logic             accept;
	logic             step;
	logic             busy;
	logic [HDR_W-1:0] in_hdr;
	logic [CNT_W-1:0] in_cnt;
	logic             in_bad;
	logic [7:0]       byte_d;
	seq_cmd_t         cmd;
	seq_cond_t        cond;
	ctl_word_t        ctl;

	for (genvar k = 0; k < MAX_OBJECTS; k++) begin : g_obj
		assign obj_load[k*OBJ_W +: OBJ_W] = s_axis_tdata[OBJ_LSB + k*OBJ_W +: OBJ_W];
	end

	assign in_hdr = s_axis_tdata[HDR_LSB +: HDR_W];
	assign in_cnt = s_axis_tdata[CNT_LSB +: CNT_W];
	assign in_bad = (s_axis_tuser == TYPE_INVALID) || (int'(in_cnt) > MAX_OBJECTS);

	assign s_axis_tready = !busy;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign step          = busy && (!m_valid_q || m_axis_tready);

	assign cmd.start   = accept;
	assign cmd.bad     = in_bad;
	assign cond.no_obj = (cnt_q == '0);
	assign cond.more   = (rem_q != REM_W'(1));

	pdtx_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.step   (step),
		.cond   (cond),
		.ctl    (ctl),
		.busy   (busy)
	);

	always_comb begin
		unique case (ctl.src)
			SRC_SOP:  byte_d = sop_token(type_q, ctl.idx);
			SRC_PACK: byte_d = TOK_PACKSYM | {3'b000, cnt_q, 2'b10};
			SRC_HLO:  byte_d = hdr_q[7:0];
			SRC_HHI:  byte_d = hdr_q[15:8];
			SRC_OBJ:  byte_d = obj_sr_q[7:0];
			SRC_TOK:  byte_d = ctl.tok;
			default:  byte_d = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_q    <= {in_hdr[15], in_cnt, in_hdr[CNT_SHIFT-1:0]};
			cnt_q    <= in_cnt;
			type_q   <= s_axis_tuser;
			rem_q    <= {in_cnt, 2'b00};
			obj_sr_q <= obj_load;
		end else if (step && ctl.src == SRC_OBJ) begin
			rem_q    <= rem_q - REM_W'(1);
			obj_sr_q <= obj_sr_q >> 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_data_q <= byte_d;
			m_last_q <= ctl.last;
			m_bad_q  <= ctl.bad;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_bad_q;

endmodule
`default_nettype wire

// ===== design/pdtx_chk.sv =====
// Port-level checker for the PD transmit token framer, bound to the top level.
`default_nettype none
module pdtx_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tuser,
	input wire logic       m_axis_tlast
);

	a_bad_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'h00)
		else $error("reject beat not a lone zero last beat");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after accept");

	a_idle_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
		else $error("idle while a non-final beat is pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("stalled output beat changed");

endmodule

bind pd_tx_token_framer pdtx_chk u_pdtx_chk (.*);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the PD transmit token framer, with a token stream scoreboard.
`timescale 1ns / 1ps
module tb;
	import pdtx_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 40;
	localparam int RANDOM_ITEMS   = 250;

	class framer_scoreboard;
		typedef struct packed {
			logic [7:0] fifo_byte;
			logic       last_byte;
			logic       bad_request;
		} token_beat_t;

		token_beat_t pending_tokens[$];
		int errors = 0;

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void push_token(logic [7:0] b);
			pending_tokens.push_back('{fifo_byte: b, last_byte: 1'b0, bad_request: 1'b0});
		endfunction

		function void note_message(logic [TYPE_W-1:0] kind, logic [HDR_W-1:0] hdr,
			logic [CNT_W-1:0] cnt, logic [NUM_OBJ_FIELDS-1:0][OBJ_W-1:0] objs);
			logic [7:0] sop [4];
			logic [HDR_W-1:0] framed_hdr;
			logic [7:0] pack_len;
			if (kind == TYPE_INVALID || cnt > MAX_OBJECTS_DEF) begin
				pending_tokens.push_back('{fifo_byte: 8'h00, last_byte: 1'b1, bad_request: 1'b1});
				return;
			end
			sop[0] = TOK_SYNC1;
			sop[1] = TOK_SYNC1;
			sop[2] = TOK_SYNC1;
			sop[3] = TOK_SYNC2;
			if (kind == TYPE_SOP_P) begin
				sop[2] = TOK_SYNC3;
				sop[3] = TOK_SYNC3;
			end else if (kind == TYPE_SOP_PP) begin
				sop[1] = TOK_SYNC3;
				sop[3] = TOK_SYNC3;
			end
			for (int i = 0; i < 4; i++) begin
				push_token(sop[i]);
			end
			pack_len = 8'(2 + 4 * int'(cnt)) & 8'h1F;
			push_token(TOK_PACKSYM | pack_len);
			framed_hdr = hdr;
			framed_hdr[CNT_SHIFT +: CNT_W] = cnt;
			push_token(framed_hdr[7:0]);
			push_token(framed_hdr[15:8]);
			for (int k = 0; k < int'(cnt); k++) begin
				for (int j = 0; j < 4; j++) begin
					push_token(objs[k][8*j +: 8]);
				end
			end
			push_token(TOK_JAMCRC);
			push_token(TOK_EOP);
			push_token(TOK_TXOFF);
			push_token(TOK_TXON);
			pending_tokens[pending_tokens.size()-1].last_byte = 1'b1;
		endfunction

		task check_beat(logic [7:0] b, logic last, logic bad);
			token_beat_t want;
			if (pending_tokens.size() == 0) begin
				report($sformatf("unexpected beat byte=%02h last=%0b bad=%0b", b, last, bad));
				return;
			end
			want = pending_tokens.pop_front();
			if (b !== want.fifo_byte)
				report($sformatf("fifo_byte %02h, want %02h", b, want.fifo_byte));
			if (last !== want.last_byte)
				report($sformatf("last_byte %0b, want %0b", last, want.last_byte));
			if (bad !== want.bad_request)
				report($sformatf("bad_request %0b, want %0b", bad, want.bad_request));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [TYPE_W-1:0]    s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 m_axis_tlast;

	framer_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	pd_tx_token_framer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_message(input logic [TYPE_W-1:0] kind, input logic [HDR_W-1:0] hdr,
		input logic [CNT_W-1:0] cnt, input logic [NUM_OBJ_FIELDS-1:0][OBJ_W-1:0] objs);
		logic [S_TDATA_W-1:0] beat;
		beat = '0;
		beat[HDR_LSB +: HDR_W] = hdr;
		beat[CNT_LSB +: CNT_W] = cnt;
		for (int k = 0; k < NUM_OBJ_FIELDS; k++) begin
			beat[OBJ_LSB + OBJ_W * k +: OBJ_W] = objs[k];
		end
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= beat;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_message(kind, hdr, cnt, objs);
		@(negedge clk);
	endtask

	task automatic send_random_message();
		logic [TYPE_W-1:0] kind;
		logic [NUM_OBJ_FIELDS-1:0][OBJ_W-1:0] objs;
		kind = ($urandom_range(99) < 10) ? TYPE_INVALID : TYPE_W'($urandom_range(2));
		for (int k = 0; k < NUM_OBJ_FIELDS; k++) begin
			objs[k] = $urandom;
		end
		send_message(kind, HDR_W'($urandom), CNT_W'($urandom_range(7)), objs);
	endtask

	initial begin
		logic [NUM_OBJ_FIELDS-1:0][OBJ_W-1:0] zeros;
		logic [NUM_OBJ_FIELDS-1:0][OBJ_W-1:0] ones;
		logic [NUM_OBJ_FIELDS-1:0][OBJ_W-1:0] mixed;
		zeros = '0;
		ones  = '1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int t = 0; t < 3; t++) begin
			send_message(TYPE_W'(t), 16'h0000, 3'd0, zeros);
			send_message(TYPE_W'(t), 16'hFFFF, 3'd7, ones);
		end
		for (int c = 1; c < 7; c++) begin
			for (int k = 0; k < NUM_OBJ_FIELDS; k++) begin
				mixed[k] = $urandom;
			end
			send_message(TYPE_W'(c % 3), HDR_W'($urandom), CNT_W'(c), mixed);
		end
		mixed = ones;
		mixed[0] = '0;
		mixed[1] = '0;
		mixed[2] = '0;
		send_message(TYPE_SOP, 16'h8FFF, 3'd3, mixed);
		send_message(TYPE_INVALID, 16'h0000, 3'd0, zeros);
		send_message(TYPE_INVALID, 16'hFFFF, 3'd7, ones);
		send_message(TYPE_INVALID, 16'h7000, 3'd2, mixed);
		send_message(TYPE_SOP_PP, 16'h7000, 3'd0, ones);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 71; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 71; end
				default: begin idle_pct = 38; stall_pct = 38; end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
				send_random_message();
			end
		end

		s_axis_tvalid <= 1'b0;
		while (sb.pending_tokens.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_tokens.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
